### design/gpni_pkg.sv
// gpni_pkg: shared types, codes and coordinate helpers for grid_point_nearest_index
// no dependencies; imported by every module of the block
package gpni_pkg;

    localparam int ID_COUNT   = 256;
    localparam int COORD_BITS = 16;
    localparam int ID_W       = $clog2(ID_COUNT);
    localparam int IO_ID_W    = 8;
    localparam int IO_COORD_W = 16;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [ID_W-1:0]              t_idx;

    typedef struct packed {
        logic   present;
        t_coord x;
        t_coord y;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_idx   idx;
        t_entry data;
    } t_wr_cmd;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_POSITION = 3'd2,
        OP_AT       = 3'd3,
        OP_NEAREST  = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_OCCUPIED  = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_NONE      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        DIR_NORTH = 2'd0,
        DIR_SOUTH = 2'd1,
        DIR_EAST  = 2'd2,
        DIR_WEST  = 2'd3
    } t_dir;

    function automatic t_coord to_coord(input logic [IO_COORD_W-1:0] raw);
        return COORD_BITS'($signed(raw));
    endfunction

    function automatic logic [IO_COORD_W-1:0] from_coord(input t_coord c);
        return IO_COORD_W'(c);
    endfunction

endpackage

### design/gpni_cell.sv
// gpni_cell: one storage cell of the rotating point ring (present flag and coordinates)
// depends on gpni_pkg
module gpni_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic             i_wr,
    input  gpni_pkg::t_entry i_wr_data,
    input  gpni_pkg::t_entry i_next,
    output gpni_pkg::t_entry o_entry
);
    import gpni_pkg::*;

    logic   r_present;
    t_coord r_x;
    t_coord r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
        end else if (i_wr) begin
            r_present <= i_wr_data.present;
        end else if (i_shift) begin
            r_present <= i_next.present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_x <= i_wr_data.x;
            r_y <= i_wr_data.y;
        end else if (i_shift) begin
            r_x <= i_next.x;
            r_y <= i_next.y;
        end
    end

    assign o_entry = '{present: r_present, x: r_x, y: r_y};

endmodule

### design/gpni_ctrl.sv
// gpni_ctrl: operation sequencer, head-of-ring compare unit and output register
// depends on gpni_pkg; sees the ring only through its head cell
module gpni_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [2:0]                        i_opcode,
    input  logic [gpni_pkg::IO_ID_W-1:0]      i_point_id,
    input  logic [gpni_pkg::IO_COORD_W-1:0]   i_x_coord,
    input  logic [gpni_pkg::IO_COORD_W-1:0]   i_y_coord,
    input  logic [1:0]                        i_direction,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [2:0]                        o_status,
    output logic                              o_found,
    output logic [gpni_pkg::IO_ID_W-1:0]      o_result_id,
    output logic [gpni_pkg::IO_COORD_W-1:0]   o_result_x,
    output logic [gpni_pkg::IO_COORD_W-1:0]   o_result_y,
    input  gpni_pkg::t_entry                  i_head,
    output logic                              o_shift,
    output gpni_pkg::t_wr_cmd                 o_wr
);
    import gpni_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_NEAR = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state  r_state, n_state;
    t_idx    r_cnt;
    t_opcode r_op;
    t_idx    r_id;
    logic    r_id_ok;
    t_coord  r_x, r_y;
    t_dir    r_dir;
    t_entry  r_own;
    logic    r_hit;
    t_idx    r_hit_id;
    logic    r_best_v;
    t_idx    r_best_id;
    t_coord  r_best_key;

    logic                    r_out_valid;
    t_status                 r_status, n_status;
    logic                    r_found, n_found;
    logic [IO_ID_W-1:0]      r_rid, n_rid;
    t_coord                  r_rx, n_rx, r_ry, n_ry;
    t_wr_cmd                 n_wr;

    logic   w_accept, w_cnt_last, w_out_free, w_fin;
    logic   w_hit, w_vert, w_up, w_line, w_beyond, w_closer, w_take, w_own_ok;
    t_coord w_key, w_ref;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_cnt_last = (r_cnt == ID_W'(ID_COUNT - 1));
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_fin      = (r_state == S_FIN) && w_out_free;
    assign o_stall    = (r_state != S_IDLE);
    assign o_shift    = (r_state == S_SCAN) || (r_state == S_NEAR);

    // at-position match during the first pass
    assign w_hit = i_head.present && (i_head.x == r_x) && (i_head.y == r_y);

    // nearest candidate during the second pass
    assign w_vert   = (r_dir == DIR_NORTH) || (r_dir == DIR_SOUTH);
    assign w_up     = (r_dir == DIR_NORTH) || (r_dir == DIR_EAST);
    assign w_line   = w_vert ? (i_head.x == r_own.x) : (i_head.y == r_own.y);
    assign w_key    = w_vert ? i_head.y : i_head.x;
    assign w_ref    = w_vert ? r_own.y : r_own.x;
    assign w_beyond = w_up ? (w_key > w_ref) : (w_key < w_ref);
    assign w_closer = !r_best_v || (w_up ? (w_key < r_best_key) : (w_key > r_best_key));
    assign w_take   = i_head.present && w_line && w_beyond && w_closer;
    assign w_own_ok = r_id_ok && r_own.present;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_cnt_last) n_state = (r_op == OP_NEAREST) ? S_NEAR : S_FIN;
            end
            S_NEAR: begin
                if (w_cnt_last) n_state = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_status = ST_OK;
        n_found  = 1'b0;
        n_rid    = '0;
        n_rx     = '0;
        n_ry     = '0;
        n_wr     = '{en: 1'b0, idx: r_id, data: '{present: 1'b0, x: r_x, y: r_y}};
        unique case (r_op)
            OP_ADD: begin
                if (!r_id_ok) begin
                    n_status = ST_NOT_FOUND;
                end else if (r_own.present) begin
                    n_status = ST_EXISTS;
                end else if (r_hit) begin
                    n_status = ST_OCCUPIED;
                end else begin
                    n_wr.en           = 1'b1;
                    n_wr.data.present = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (!w_own_ok) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_wr.en = 1'b1;
                end
            end
            OP_POSITION: begin
                if (!w_own_ok) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_rx = r_own.x;
                    n_ry = r_own.y;
                end
            end
            OP_AT: begin
                n_found = r_hit;
                if (r_hit) n_rid = IO_ID_W'(r_hit_id);
            end
            OP_NEAREST: begin
                if (!w_own_ok) begin
                    n_status = ST_NOT_FOUND;
                end else if (!r_best_v) begin
                    n_status = ST_NONE;
                end else begin
                    n_rid = IO_ID_W'(r_best_id);
                end
            end
            default: ;
        endcase
    end

    assign o_wr = '{en: n_wr.en && w_fin, idx: n_wr.idx, data: n_wr.data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_rid    <= n_rid;
            r_rx     <= n_rx;
            r_ry     <= n_ry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= t_opcode'(i_opcode);
            r_id     <= ID_W'(i_point_id);
            r_id_ok  <= (32'(i_point_id) < 32'(ID_COUNT));
            r_x      <= to_coord(i_x_coord);
            r_y      <= to_coord(i_y_coord);
            r_dir    <= t_dir'(i_direction);
            r_cnt    <= '0;
            r_hit    <= 1'b0;
            r_best_v <= 1'b0;
        end else if (o_shift) begin
            r_cnt <= w_cnt_last ? '0 : r_cnt + 1'b1;
            if (r_state == S_SCAN) begin
                if (r_cnt == r_id) r_own <= i_head;
                if (w_hit && !r_hit) begin
                    r_hit    <= 1'b1;
                    r_hit_id <= r_cnt;
                end
            end else if (w_take) begin
                r_best_v   <= 1'b1;
                r_best_id  <= r_cnt;
                r_best_key <= w_key;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_found     = r_found;
    assign o_result_id = r_rid;
    assign o_result_x  = from_coord(r_rx);
    assign o_result_y  = from_coord(r_ry);

endmodule

### design/grid_point_nearest_index.sv
// grid_point_nearest_index: point table on a 2D grid with add, remove, position,
// at-position and nearest-in-direction lookups; depends on gpni_pkg, gpni_cell, gpni_ctrl
//
// Usage: one request word (opcode, point_id, x_coord, y_coord, direction) goes in on
// i_valid/o_stall, one result word (status, found, result_id, result_x, result_y)
// comes out on o_valid/i_stall. The table sits in a ring of ID_COUNT cells, one per
// id, that rotates one place per cycle past a single compare unit at its head while
// a request is in its scan. Every request makes one full turn of the ring; nearest
// makes a second turn once its own coordinates are known. The block takes one request
// at a time: a new request is taken only once the last one's result is registered.
// Table updates are written in the final state, when the ring is back in its home
// position.
// The result sits in an output register: a new request is taken while a result is
// still stalled, and the block holds its final cycle until that register frees up.
// Reset (i_rst_n low, synchronous) empties the table at once and drops o_valid.
module grid_point_nearest_index (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [2:0]                        i_opcode,
    input  logic [gpni_pkg::IO_ID_W-1:0]      i_point_id,
    input  logic [gpni_pkg::IO_COORD_W-1:0]   i_x_coord,
    input  logic [gpni_pkg::IO_COORD_W-1:0]   i_y_coord,
    input  logic [1:0]                        i_direction,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [2:0]                        o_status,
    output logic                              o_found,
    output logic [gpni_pkg::IO_ID_W-1:0]      o_result_id,
    output logic [gpni_pkg::IO_COORD_W-1:0]   o_result_x,
    output logic [gpni_pkg::IO_COORD_W-1:0]   o_result_y
);
    import gpni_pkg::*;

    t_entry  w_cell [ID_COUNT];
    logic    w_shift;
    t_wr_cmd w_wr;

    // cell i takes from cell i+1; cell 0 is the head and feeds the last cell
    for (genvar i = 0; i < ID_COUNT; i++) begin : g_ring
        localparam int NXT = (i + 1) % ID_COUNT;
        gpni_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (w_shift),
            .i_wr      (w_wr.en && (w_wr.idx == ID_W'(i))),
            .i_wr_data (w_wr.data),
            .i_next    (w_cell[NXT]),
            .o_entry   (w_cell[i])
        );
    end

    gpni_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_point_id  (i_point_id),
        .i_x_coord   (i_x_coord),
        .i_y_coord   (i_y_coord),
        .i_direction (i_direction),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_found     (o_found),
        .o_result_id (o_result_id),
        .o_result_x  (o_result_x),
        .o_result_y  (o_result_y),
        .i_head      (w_cell[0]),
        .o_shift     (w_shift),
        .o_wr        (w_wr)
    );

endmodule

### design/gpni_checker.sv
// gpni_checker: port-level assertions for grid_point_nearest_index, bound to the top level
// depends on gpni_pkg
module gpni_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [2:0]                        o_status,
    input logic                              o_found,
    input logic [gpni_pkg::IO_ID_W-1:0]      o_result_id,
    input logic [gpni_pkg::IO_COORD_W-1:0]   o_result_x,
    input logic [gpni_pkg::IO_COORD_W-1:0]   o_result_y
);
    import gpni_pkg::*;

    // a taken request keeps the block busy for its scan
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after taking a word");

    // a stalled result stays put
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_found)
            && $stable(o_result_id) && $stable(o_result_x) && $stable(o_result_y)))
        else $error("stalled result word changed");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_status == ST_OK))
        else $error("hit reported with error status");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |->
            (!o_found && (o_result_id == '0) && (o_result_x == '0) && (o_result_y == '0)))
        else $error("error result carries payload");

endmodule

bind grid_point_nearest_index gpni_checker u_gpni_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_status    (o_status),
    .o_found     (o_found),
    .o_result_id (o_result_id),
    .o_result_x  (o_result_x),
    .o_result_y  (o_result_y)
);

### tb/tb_grid_point_nearest_index.sv
// tb_grid_point_nearest_index: self-checking testbench for the grid point table
// depends on gpni_pkg and grid_point_nearest_index; a scoreboard class predicts each
// result word from its own copy of the table, random gaps and stalls on both channels
module tb_grid_point_nearest_index;
    import gpni_pkg::*;

    localparam int HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES = 2 * ID_COUNT + 16;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    class grid_scoreboard;
        typedef struct {
            logic [2:0]  status;
            logic        found;
            logic [7:0]  rid;
            logic [15:0] rx;
            logic [15:0] ry;
        } t_answer;

        bit      occupied_id[ID_COUNT];
        t_coord  cell_x[ID_COUNT];
        t_coord  cell_y[ID_COUNT];
        t_answer answers_due[$];
        int      failures;

        function int owner_of(t_coord x, t_coord y);
            for (int i = 0; i < ID_COUNT; i++)
                if (occupied_id[i] && cell_x[i] == x && cell_y[i] == y)
                    return i;
            return -1;
        endfunction

        function int nearest_from(int id, t_dir dir);
            int     best;
            t_coord best_key;
            t_coord key;
            t_coord own;
            bit     vertical;
            bit     upward;
            best     = -1;
            best_key = '0;
            vertical = (dir == DIR_NORTH || dir == DIR_SOUTH);
            upward   = (dir == DIR_NORTH || dir == DIR_EAST);
            own      = vertical ? cell_y[id] : cell_x[id];
            for (int i = 0; i < ID_COUNT; i++) begin
                if (!occupied_id[i])
                    continue;
                if (vertical ? (cell_x[i] != cell_x[id]) : (cell_y[i] != cell_y[id]))
                    continue;
                key = vertical ? cell_y[i] : cell_x[i];
                if (upward ? (key <= own) : (key >= own))
                    continue;
                if (best < 0 || (upward ? (key < best_key) : (key > best_key))) begin
                    best     = i;
                    best_key = key;
                end
            end
            return best;
        endfunction

        function void note_request(logic [2:0] op, logic [7:0] id, logic [15:0] xr,
                                   logic [15:0] yr, logic [1:0] dr);
            t_answer a;
            t_coord  x;
            t_coord  y;
            int      hit;
            a = '{default: '0};
            x = t_coord'(xr);
            y = t_coord'(yr);
            case (op)
                OP_ADD: begin
                    if (occupied_id[id])
                        a.status = ST_EXISTS;
                    else if (owner_of(x, y) >= 0)
                        a.status = ST_OCCUPIED;
                    else begin
                        occupied_id[id] = 1'b1;
                        cell_x[id]      = x;
                        cell_y[id]      = y;
                    end
                end
                OP_REMOVE: begin
                    if (!occupied_id[id])
                        a.status = ST_NOT_FOUND;
                    else
                        occupied_id[id] = 1'b0;
                end
                OP_POSITION: begin
                    if (!occupied_id[id])
                        a.status = ST_NOT_FOUND;
                    else begin
                        a.rx = cell_x[id];
                        a.ry = cell_y[id];
                    end
                end
                OP_AT: begin
                    hit = owner_of(x, y);
                    if (hit >= 0) begin
                        a.found = 1'b1;
                        a.rid   = 8'(hit);
                    end
                end
                OP_NEAREST: begin
                    if (!occupied_id[id])
                        a.status = ST_NOT_FOUND;
                    else begin
                        hit = nearest_from(id, t_dir'(dr));
                        if (hit < 0)
                            a.status = ST_NONE;
                        else
                            a.rid = 8'(hit);
                    end
                end
                default: ;
            endcase
            answers_due.push_back(a);
        endfunction

        function void check_result(logic [2:0] st, logic fd, logic [7:0] rid,
                                   logic [15:0] rx, logic [15:0] ry);
            t_answer a;
            if (answers_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result word: status %0d found %0d id %0d x %h y %h",
                             st, fd, rid, rx, ry);
                return;
            end
            a = answers_due.pop_front();
            if (a.status !== st || a.found !== fd || a.rid !== rid || a.rx !== rx ||
                a.ry !== ry) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch at %0t: exp %0d %0d %0d %h %h, got %0d %0d %0d %h %h",
                             $time, a.status, a.found, a.rid, a.rx, a.ry,
                             st, fd, rid, rx, ry);
            end
        endfunction

        function int pending();
            return answers_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_opcode;
    logic [7:0]  i_point_id;
    logic [15:0] i_x_coord;
    logic [15:0] i_y_coord;
    logic [1:0]  i_direction;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic        o_found;
    logic [7:0]  o_result_id;
    logic [15:0] o_result_x;
    logic [15:0] o_result_y;

    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    bit hold_off_req = 1'b0;

    grid_scoreboard sb = new();

    grid_point_nearest_index u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_point_id  (i_point_id),
        .i_x_coord   (i_x_coord),
        .i_y_coord   (i_y_coord),
        .i_direction (i_direction),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_found     (o_found),
        .o_result_id (o_result_id),
        .o_result_x  (o_result_x),
        .o_result_y  (o_result_y)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic send_word(input logic [2:0] op, input logic [7:0] id,
                             input logic [15:0] x, input logic [15:0] y,
                             input logic [1:0] dr);
        if (send_idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_point_id  <= id;
        i_x_coord   <= x;
        i_y_coord   <= y;
        i_direction <= dr;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(op, id, x, y, dr);
    endtask

    // mostly small ids and a small patch of cells so rows and columns get crowded
    task automatic send_random_word();
        int          pick;
        logic [2:0]  op;
        logic [7:0]  id;
        logic [15:0] x;
        logic [15:0] y;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            op = OP_ADD;
        else if (pick < 35)
            op = OP_REMOVE;
        else if (pick < 50)
            op = OP_POSITION;
        else if (pick < 68)
            op = OP_AT;
        else if (pick < 95)
            op = OP_NEAREST;
        else
            op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        id = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 23));
        x  = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 6) - 3);
        y  = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 6) - 3);
        send_word(op, id, x, y, 2'($urandom()));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_status, o_found, o_result_id, o_result_x, o_result_y);
    end

    initial begin
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_opcode    <= '0;
        i_point_id  <= '0;
        i_x_coord   <= '0;
        i_y_coord   <= '0;
        i_direction <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners of the grid, duplicate id and taken cell
        send_word(OP_ADD, 8'd0, 16'h8000, 16'h8000, DIR_NORTH);
        send_word(OP_ADD, 8'd255, 16'h7fff, 16'h7fff, DIR_NORTH);
        send_word(OP_ADD, 8'd0, 16'h0001, 16'h0001, DIR_NORTH);
        send_word(OP_ADD, 8'd1, 16'h7fff, 16'h7fff, DIR_NORTH);
        send_word(OP_ADD, 8'd1, 16'h8000, 16'h7fff, DIR_NORTH);
        send_word(OP_ADD, 8'd2, 16'h7fff, 16'h8000, DIR_NORTH);
        // nearest in each direction, with and without a neighbor
        send_word(OP_NEAREST, 8'd0, 16'h0000, 16'h0000, DIR_NORTH);
        send_word(OP_NEAREST, 8'd0, 16'h0000, 16'h0000, DIR_SOUTH);
        send_word(OP_NEAREST, 8'd0, 16'h0000, 16'h0000, DIR_EAST);
        send_word(OP_NEAREST, 8'd0, 16'h0000, 16'h0000, DIR_WEST);
        send_word(OP_NEAREST, 8'd255, 16'hffff, 16'hffff, DIR_SOUTH);
        send_word(OP_NEAREST, 8'd255, 16'hffff, 16'hffff, DIR_WEST);
        send_word(OP_NEAREST, 8'd3, 16'h0000, 16'h0000, DIR_NORTH);
        send_word(OP_POSITION, 8'd255, 16'h0000, 16'h0000, DIR_NORTH);
        send_word(OP_POSITION, 8'd3, 16'h0000, 16'h0000, DIR_NORTH);
        send_word(OP_AT, 8'd0, 16'h7fff, 16'h8000, DIR_NORTH);
        send_word(OP_AT, 8'd0, 16'h0000, 16'h0000, DIR_NORTH);
        send_word(OP_REMOVE, 8'd2, 16'h0000, 16'h0000, DIR_NORTH);
        send_word(OP_REMOVE, 8'd2, 16'h0000, 16'h0000, DIR_NORTH);
        send_word(OP_NEAREST, 8'd0, 16'h0000, 16'h0000, DIR_EAST);
        send_word(OP_UNUSED_FIRST, 8'd170, 16'h5555, 16'haaaa, DIR_EAST);
        send_word(OP_UNUSED_LAST, 8'd85, 16'haaaa, 16'h5555, DIR_WEST);
        send_word(OP_ADD, 8'd170, 16'h5555, 16'haaaa, DIR_NORTH);
        send_word(OP_POSITION, 8'd170, 16'h0000, 16'h0000, DIR_NORTH);

        repeat (600) send_random_word();
        // long receiver hold-off so the block backs up into its input
        hold_off_req = 1'b1;
        repeat (600) send_random_word();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        repeat (300) send_random_word();
        i_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

### filelist.f
design/gpni_pkg.sv
design/gpni_cell.sv
design/gpni_ctrl.sv
design/grid_point_nearest_index.sv
design/gpni_checker.sv
tb/tb_grid_point_nearest_index.sv
